>>> rtl/core/lwetkd_pkg.sv
// ----------------------------------------------------------------------------
// lwetkd_pkg
// Shared types and constants of the LWE ternary-key decryption engine:
// field widths, lane geometry, operation codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package lwetkd_pkg;

  // Field widths of the input and result transactions
  localparam int OP_W    = 2;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 8;
  localparam int KEY_W   = 2;
  localparam int COEFF_W = 16;
  localparam int WORD_W  = 64;
  localparam int WIDX_W  = 2;

  // Sixteen accumulator lanes per cycle; a group is one row of lanes
  localparam int LANE_W = 4;
  localparam int LANES  = 1 << LANE_W;
  localparam int GRP_W  = COL_W - LANE_W;
  // Bits to index the groups of one 64-bit output word
  localparam int SLOT_W = $clog2(WORD_W / LANES);

  // Rounding constant and plaintext bit position
  localparam logic [COEFF_W-1:0] ROUND_ADD = 16'h4000;
  localparam int                 PLAIN_BIT = 15;

  // Default geometry
  localparam int DEF_KEY_ROWS = 536;
  localparam int DEF_MSG_BITS = 256;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_LOAD_B   = 2'd1,
    OP_ACCUM    = 2'd2,
    OP_FINISH   = 2'd3
  } op_t;

  // Controller -> datapath
  typedef struct packed {
    logic             capture;   // latch row and coefficient of the transaction
    logic             key_we;    // write one key entry from the input
    logic             b_we;      // write one accumulator from the input
    logic             acc_rd;    // read a group for accumulation
    logic             fin_rd;    // read a group for finishing
    logic             out_load;  // move the assembled word to the output
    logic             last;      // the word being loaded is the final one
    logic [GRP_W-1:0] grp;       // current group
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_t  op;
    logic row_ok;
    logic col_ok;
    logic out_free;
    logic wb_busy;
  } status_t;

endpackage

>>> rtl/core/lwe_ternary_key_decryption.sv
// ----------------------------------------------------------------------------
// lwe_ternary_key_decryption
// LWE/LWR decryption engine with a ternary secret key: key and b loads,
// a-element accumulation over sixteen lanes, and rounding into packed
// 64-bit plaintext words.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid, in_ready, operation, row_index,       | input
//           | column_index, key_value, coeff_value            |
//   out     | out_valid, out_ready, plaintext_word,           | output
//           | word_index, last_word                           |
//
// An accumulate steps through every accumulator group, the sixteen
// add/subtract lanes working one accumulator group per cycle through the
// lane RAMs. A finish reads and rounds each group and pushes each
// completed output word. Reset clears control only; key and accumulator
// RAMs are not cleared. A stalled output holds the finish pass at its word
// push, and no new transaction is accepted until the final word has moved
// to the output register.
// ----------------------------------------------------------------------------
module lwe_ternary_key_decryption #(
  parameter int KEY_ROWS = lwetkd_pkg::DEF_KEY_ROWS,
  parameter int MSG_BITS = lwetkd_pkg::DEF_MSG_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic        [lwetkd_pkg::OP_W-1:0]    operation,
  input  logic        [lwetkd_pkg::ROW_W-1:0]   row_index,
  input  logic        [lwetkd_pkg::COL_W-1:0]   column_index,
  input  logic signed [lwetkd_pkg::KEY_W-1:0]   key_value,
  input  logic        [lwetkd_pkg::COEFF_W-1:0] coeff_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [lwetkd_pkg::WORD_W-1:0]  plaintext_word,
  output logic        [lwetkd_pkg::WIDX_W-1:0]  word_index,
  output logic                                  last_word
);
  import lwetkd_pkg::*;

  cmd_t    cmd;
  status_t st;

  lwetkd_ctrl #(.MSG_BITS(MSG_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lwetkd_datapath #(.KEY_ROWS(KEY_ROWS), .MSG_BITS(MSG_BITS)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .operation      (operation),
    .row_index      (row_index),
    .column_index   (column_index),
    .key_value      (key_value),
    .coeff_value    (coeff_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .plaintext_word (plaintext_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  // Writeback owns the accumulator write port; a b load must never collide
  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    st.wb_busy |-> !cmd.b_we)
    else $error("b load collides with accumulator writeback");

  // A word only moves to the output when the register is free
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("output register overwritten");

  // The final word shows up flagged as last
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.last) |=> (out_valid && last_word))
    else $error("final word not flagged");

  // No new transaction while a pass is running
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.acc_rd || cmd.fin_rd) |-> !in_ready)
    else $error("transaction accepted during a pass");

endmodule

>>> rtl/core/lwetkd_ram.sv
// ----------------------------------------------------------------------------
// lwetkd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lwetkd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lwetkd_datapath.sv
// ----------------------------------------------------------------------------
// lwetkd_datapath
// Key store and accumulators split into sixteen lanes, the per-lane
// add/subtract units, the plaintext word assembly and the output register.
// ----------------------------------------------------------------------------
module lwetkd_datapath #(
  parameter int KEY_ROWS = lwetkd_pkg::DEF_KEY_ROWS,
  parameter int MSG_BITS = lwetkd_pkg::DEF_MSG_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lwetkd_pkg::cmd_t                      cmd,
  output lwetkd_pkg::status_t                   st,
  input  logic        [lwetkd_pkg::OP_W-1:0]    operation,
  input  logic        [lwetkd_pkg::ROW_W-1:0]   row_index,
  input  logic        [lwetkd_pkg::COL_W-1:0]   column_index,
  input  logic signed [lwetkd_pkg::KEY_W-1:0]   key_value,
  input  logic        [lwetkd_pkg::COEFF_W-1:0] coeff_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [lwetkd_pkg::WORD_W-1:0]  plaintext_word,
  output logic        [lwetkd_pkg::WIDX_W-1:0]  word_index,
  output logic                                  last_word
);
  import lwetkd_pkg::*;

  localparam int GROUPS = (MSG_BITS + LANES - 1) / LANES;
  localparam int AW     = $clog2(GROUPS);
  localparam int KDEPTH = KEY_ROWS * GROUPS;
  localparam int KAW    = $clog2(KDEPTH);
  localparam int PW     = ROW_W + GRP_W + 1;
  localparam int SLOTS  = 1 << SLOT_W;

  // Key weight (+1, -1, -2 or 0) times coefficient, mod 2^16
  function automatic logic [COEFF_W-1:0] weighted(input logic [COEFF_W-1:0] c,
                                                  input logic [KEY_W-1:0]   k);
    logic [COEFF_W-1:0] r;
    case (k)
      2'b01:   r = c;
      2'b11:   r = COEFF_W'(0) - c;
      2'b10:   r = COEFF_W'(0) - {c[COEFF_W-2:0], 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [ROW_W-1:0]   row_q;
  logic [COEFF_W-1:0] coeff_q;
  logic               wb_valid;
  logic               fin_valid;
  logic [GRP_W-1:0]   rd_grp_q;
  logic [WORD_W-1:0]  word_q;

  logic [GRP_W-1:0]   col_grp;
  logic [PW-1:0]      key_wbase;
  logic [PW-1:0]      key_rbase;
  logic [KAW-1:0]     key_waddr;
  logic [KAW-1:0]     key_raddr;
  logic [AW-1:0]      acc_waddr;

  logic [KEY_W-1:0]   key_rd    [LANES];
  logic [COEFF_W-1:0] acc_rd    [LANES];
  logic [COEFF_W-1:0] acc_sum   [LANES];
  logic [COEFF_W-1:0] acc_rnd   [LANES];
  logic [COEFF_W-1:0] acc_wdata [LANES];
  logic [LANES-1:0]   key_we;
  logic [LANES-1:0]   acc_we;
  logic [LANES-1:0]   lane_ok;
  logic [LANES-1:0]   fin_bits;

  // Status back to the controller
  assign st.op       = op_t'(operation);
  assign st.row_ok   = {1'b0, row_index} < (ROW_W + 1)'(KEY_ROWS);
  assign st.col_ok   = {1'b0, column_index} < (COL_W + 1)'(MSG_BITS);
  assign st.out_free = !out_valid || out_ready;
  assign st.wb_busy  = wb_valid;

  // Key store addressing: row * GROUPS + group
  assign col_grp   = column_index[COL_W-1:LANE_W];
  assign key_wbase = PW'(row_index) * PW'(GROUPS) + PW'(col_grp);
  assign key_rbase = PW'(row_q) * PW'(GROUPS) + PW'(cmd.grp);
  assign key_waddr = key_wbase[KAW-1:0];
  assign key_raddr = key_rbase[KAW-1:0];

  // Accumulator write port: writeback has the port, else a b load
  assign acc_waddr = wb_valid ? rd_grp_q[AW-1:0] : col_grp[AW-1:0];

  // Lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign key_we[l]    = cmd.key_we && (column_index[LANE_W-1:0] == LANE_W'(l));
    assign lane_ok[l]   = {1'b0, rd_grp_q, LANE_W'(l)} < (COL_W + 1)'(MSG_BITS);
    assign acc_sum[l]   = acc_rd[l] + weighted(coeff_q, key_rd[l]);
    assign acc_rnd[l]   = acc_rd[l] + ROUND_ADD;
    assign fin_bits[l]  = lane_ok[l] && acc_rnd[l][PLAIN_BIT];
    assign acc_we[l]    = wb_valid ? lane_ok[l]
                        : (cmd.b_we && (column_index[LANE_W-1:0] == LANE_W'(l)));
    assign acc_wdata[l] = wb_valid ? acc_sum[l] : coeff_value;

    lwetkd_ram #(.WIDTH(KEY_W), .DEPTH(KDEPTH)) u_key_ram (
      .clk   (clk),
      .we    (key_we[l]),
      .waddr (key_waddr),
      .wdata (key_value),
      .raddr (key_raddr),
      .rdata (key_rd[l])
    );

    lwetkd_ram #(.WIDTH(COEFF_W), .DEPTH(GROUPS)) u_acc_ram (
      .clk   (clk),
      .we    (acc_we[l]),
      .waddr (acc_waddr),
      .wdata (acc_wdata[l]),
      .raddr (cmd.grp[AW-1:0]),
      .rdata (acc_rd[l])
    );
  end

  // Captured operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_q   <= row_index;
      coeff_q <= coeff_value;
    end
  end

  // Read stage tracking: data of the group read last cycle is valid now
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid  <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      wb_valid  <= cmd.acc_rd;
      fin_valid <= cmd.fin_rd;
    end
    rd_grp_q <= cmd.grp;
  end

  // Word assembly; the first slot of a word clears the rest
  always_ff @(posedge clk) begin
    if (fin_valid) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (rd_grp_q[SLOT_W-1:0] == SLOT_W'(s)) begin
          word_q[s*LANES +: LANES] <= fin_bits;
        end else if (rd_grp_q[SLOT_W-1:0] == '0) begin
          word_q[s*LANES +: LANES] <= '0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      plaintext_word <= word_q;
      word_index     <= WIDX_W'(cmd.grp >> SLOT_W);
      last_word      <= cmd.last;
    end
  end

endmodule

>>> rtl/core/lwetkd_ctrl.sv
// ----------------------------------------------------------------------------
// lwetkd_ctrl
// Sequencer: decodes each transaction, steps the group counter through the
// accumulate and finish passes and paces the output words.
// ----------------------------------------------------------------------------
module lwetkd_ctrl #(
  parameter int MSG_BITS = lwetkd_pkg::DEF_MSG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lwetkd_pkg::status_t st,
  output lwetkd_pkg::cmd_t    cmd
);
  import lwetkd_pkg::*;

  localparam int               GROUPS   = (MSG_BITS + LANES - 1) / LANES;
  localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(GROUPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DRAIN,
    S_FIN,
    S_FIN_COL,
    S_PUSH
  } state_t;

  state_t           state;
  logic [GRP_W-1:0] grp;
  logic             accept;
  logic             grp_last;
  logic             word_done;

  assign accept    = in_valid && in_ready;
  assign grp_last  = (grp == LAST_GRP);
  assign word_done = (grp[SLOT_W-1:0] == {SLOT_W{1'b1}}) || grp_last;

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.grp      = grp;
    cmd.capture  = accept;
    cmd.key_we   = accept && (st.op == OP_LOAD_KEY) && st.row_ok && st.col_ok;
    cmd.b_we     = accept && (st.op == OP_LOAD_B) && st.col_ok;
    cmd.acc_rd   = (state == S_ACC);
    cmd.fin_rd   = (state == S_FIN);
    cmd.out_load = (state == S_PUSH) && st.out_free;
    cmd.last     = grp_last;
  end

  // State, group counter and ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      grp      <= '0;
      in_ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          grp <= '0;
          if (accept && (st.op == OP_ACCUM) && st.row_ok) begin
            state    <= S_ACC;
            in_ready <= 1'b0;
          end else if (accept && (st.op == OP_FINISH)) begin
            state    <= S_FIN;
            in_ready <= 1'b0;
          end
        end
        S_ACC: begin
          if (grp_last) begin
            state <= S_DRAIN;
          end else begin
            grp <= grp + 1'b1;
          end
        end
        S_DRAIN: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
        S_FIN: begin
          state <= S_FIN_COL;
        end
        S_FIN_COL: begin
          if (word_done) begin
            state <= S_PUSH;
          end else begin
            grp   <= grp + 1'b1;
            state <= S_FIN;
          end
        end
        S_PUSH: begin
          if (st.out_free) begin
            if (grp_last) begin
              state    <= S_IDLE;
              in_ready <= 1'b1;
            end else begin
              grp   <= grp + 1'b1;
              state <= S_FIN;
            end
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule
